[design/hbpwm_pkg.sv]
`default_nettype none

package hbpwm_pkg;

  localparam int unsigned CHANNELS = 2;
  localparam int unsigned CH_W     = 1;
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned COAST_W  = 8;
  localparam int unsigned MAG_W    = 7;
  localparam int unsigned PCT_W    = 8;
  localparam int unsigned PROD_W   = MAG_W + PERIOD_W;
  localparam int unsigned Y_W      = PROD_W - 2;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic signed [DUTY_W-1:0] DUTY_MAX = 16'sd100;
  localparam logic signed [DUTY_W-1:0] DUTY_MIN = -16'sd100;
  localparam logic signed [PCT_W-1:0]  PCT_MAX  = 8'sd100;
  localparam logic signed [PCT_W-1:0]  PCT_MIN  = -8'sd100;

  // ceil(2^32 / 25), split in halves for two narrow multipliers
  localparam int unsigned RECIP_W      = 28;
  localparam int unsigned RECIP_HALF_W = RECIP_W / 2;
  localparam int unsigned RECIP_SHIFT  = 32;
  localparam logic [RECIP_W-1:0] RECIP_25 = 28'd171798692;
  localparam logic [RECIP_HALF_W-1:0] RECIP_HI = RECIP_25[RECIP_W-1:RECIP_HALF_W];
  localparam logic [RECIP_HALF_W-1:0] RECIP_LO = RECIP_25[RECIP_HALF_W-1:0];
  localparam int unsigned PP_W   = Y_W + RECIP_HALF_W;
  localparam int unsigned QSUM_W = PP_W + RECIP_HALF_W;

  localparam logic [COAST_W-1:0]  COAST_RESET  = 8'd4;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd3
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INVERT_LEFT  = 8'd0,
    REG_INVERT_RIGHT = 8'd1,
    REG_COAST_CALLS  = 8'd2,
    REG_PWM_PERIOD   = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                invert_left;
    logic                invert_right;
    logic [COAST_W-1:0]  coast_calls;
    logic [PERIOD_W-1:0] pwm_period;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic             neg;
    logic             forced;
    logic [MAG_W-1:0] mag;
  } cmd_t;

endpackage

`default_nettype wire

[design/hbridge_pwm_with_reversal_coast.sv]
// channel | direction | ports
// in      | to block  | in_valid, in_ready, in_channel, in_duty_cmd
// out     | from block| out_valid, out_ready, out_channel, out_in1_compare,
//         |           | out_in2_compare, out_coasting
// cfg     | to block  | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// one command per cycle unless out_ready backs up the stages; a command passes
// through input reg, direction/coast update with duty*period, /100 partial
// products and output reg before out_valid rises. cfg_ready is always high.
// synchronous active-low reset clears config to defaults and per-motor state.
// stages advance independently, so bubbles collapse when out_ready is low.
`default_nettype none

module hbridge_pwm_with_reversal_coast (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic [hbpwm_pkg::CH_W-1:0]              in_channel,
  input  wire logic signed [hbpwm_pkg::DUTY_W-1:0]     in_duty_cmd,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic [hbpwm_pkg::CH_W-1:0]                   out_channel,
  output logic [hbpwm_pkg::PERIOD_W-1:0]               out_in1_compare,
  output logic [hbpwm_pkg::PERIOD_W-1:0]               out_in2_compare,
  output logic                                         out_coasting,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [hbpwm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [hbpwm_pkg::CFG_DATA_W-1:0]        cfg_data
);

  hbpwm_pkg::cfg_t cfg_r;

  logic                                   v1_r, v2_r, v3_r, vo_r;
  logic                                   ld1, ld2, ld3, ldo;
  logic [hbpwm_pkg::CH_W-1:0]             ch1_r;
  logic signed [hbpwm_pkg::DUTY_W-1:0]    duty1_r;
  hbpwm_pkg::cmd_t                        cmd;
  hbpwm_pkg::cmd_t                        cmd2_r;
  logic [hbpwm_pkg::PROD_W-1:0]           prod2_r;
  logic [hbpwm_pkg::Y_W-1:0]              y;
  logic [hbpwm_pkg::CH_W-1:0]             ch3_r;
  logic                                   neg3_r, forced3_r;
  logic [hbpwm_pkg::PP_W-1:0]             pphi3_r, pplo3_r;
  logic [hbpwm_pkg::QSUM_W-1:0]           qsum;
  logic [hbpwm_pkg::PERIOD_W-1:0]         mag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert_left  <= 1'b0;
      cfg_r.invert_right <= 1'b1;
      cfg_r.coast_calls  <= hbpwm_pkg::COAST_RESET;
      cfg_r.pwm_period   <= hbpwm_pkg::PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hbpwm_pkg::REG_INVERT_LEFT:  cfg_r.invert_left  <= cfg_data[0];
        hbpwm_pkg::REG_INVERT_RIGHT: cfg_r.invert_right <= cfg_data[0];
        hbpwm_pkg::REG_COAST_CALLS:  cfg_r.coast_calls  <= cfg_data[hbpwm_pkg::COAST_W-1:0];
        hbpwm_pkg::REG_PWM_PERIOD:   cfg_r.pwm_period   <= cfg_data[hbpwm_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign ldo      = !vo_r || out_ready;
  assign ld3      = !v3_r || ldo;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ldo) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && in_valid) begin
      ch1_r   <= in_channel;
      duty1_r <= in_duty_cmd;
    end
  end

  hbpwm_dir u_dir (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en   (ld2 && v1_r),
    .channel  (ch1_r),
    .duty_cmd (duty1_r),
    .cfg      (cfg_r),
    .cmd      (cmd)
  );

  always_ff @(posedge clk) begin
    if (ld2 && v1_r) begin
      cmd2_r  <= cmd;
      prod2_r <= hbpwm_pkg::PROD_W'(cmd.mag) * hbpwm_pkg::PROD_W'(cfg_r.pwm_period);
    end
  end

  // x/100 as (x>>2)/25 by reciprocal multiply
  assign y = prod2_r[hbpwm_pkg::PROD_W-1:2];

  always_ff @(posedge clk) begin
    if (ld3 && v2_r) begin
      ch3_r     <= cmd2_r.channel;
      neg3_r    <= cmd2_r.neg;
      forced3_r <= cmd2_r.forced;
      pphi3_r   <= hbpwm_pkg::PP_W'(y) * hbpwm_pkg::PP_W'(hbpwm_pkg::RECIP_HI);
      pplo3_r   <= hbpwm_pkg::PP_W'(y) * hbpwm_pkg::PP_W'(hbpwm_pkg::RECIP_LO);
    end
  end

  assign qsum = {pphi3_r, {hbpwm_pkg::RECIP_HALF_W{1'b0}}} +
                hbpwm_pkg::QSUM_W'(pplo3_r);
  assign mag  = qsum[hbpwm_pkg::RECIP_SHIFT +: hbpwm_pkg::PERIOD_W];

  always_ff @(posedge clk) begin
    if (ldo && v3_r) begin
      out_channel     <= ch3_r;
      out_in1_compare <= neg3_r ? '0 : mag;
      out_in2_compare <= neg3_r ? mag : '0;
      out_coasting    <= forced3_r;
    end
  end

  assign out_valid = vo_r;

endmodule

`default_nettype wire

[design/hbpwm_dir.sv]
`default_nettype none

module hbpwm_dir (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                upd_en,
  input  wire logic [hbpwm_pkg::CH_W-1:0]          channel,
  input  wire logic signed [hbpwm_pkg::DUTY_W-1:0] duty_cmd,
  input  wire hbpwm_pkg::cfg_t                     cfg,
  output hbpwm_pkg::cmd_t                          cmd
);

  hbpwm_pkg::dir_t                   dir_r   [hbpwm_pkg::CHANNELS];
  hbpwm_pkg::dir_t                   dir_nxt [hbpwm_pkg::CHANNELS];
  logic [hbpwm_pkg::COAST_W-1:0]     rem_r   [hbpwm_pkg::CHANNELS];
  logic [hbpwm_pkg::COAST_W-1:0]     rem_nxt [hbpwm_pkg::CHANNELS];

  logic signed [hbpwm_pkg::PCT_W-1:0] clamped;
  logic signed [hbpwm_pkg::PCT_W-1:0] oriented;
  logic signed [hbpwm_pkg::PCT_W-1:0] eff;
  logic [hbpwm_pkg::PCT_W-1:0]        eff_abs;
  logic                               inv;
  logic                               forced;
  hbpwm_pkg::dir_t                    want;

  always_comb begin
    if (duty_cmd > hbpwm_pkg::DUTY_MAX) begin
      clamped = hbpwm_pkg::PCT_MAX;
    end else if (duty_cmd < hbpwm_pkg::DUTY_MIN) begin
      clamped = hbpwm_pkg::PCT_MIN;
    end else begin
      clamped = duty_cmd[hbpwm_pkg::PCT_W-1:0];
    end
    inv      = (channel == '0) ? cfg.invert_left : cfg.invert_right;
    oriented = inv ? -clamped : clamped;
    if (oriented > 0) begin
      want = hbpwm_pkg::DIR_FWD;
    end else if (oriented < 0) begin
      want = hbpwm_pkg::DIR_REV;
    end else begin
      want = hbpwm_pkg::DIR_NONE;
    end
  end

  // reversal protection, skipped entirely when coast_calls is zero
  always_comb begin
    dir_nxt = dir_r;
    rem_nxt = rem_r;
    forced  = 1'b0;
    if (cfg.coast_calls != '0) begin
      if (rem_r[channel] != '0) begin
        rem_nxt[channel] = rem_r[channel] - 1'b1;
        forced           = 1'b1;
      end else if (want != hbpwm_pkg::DIR_NONE && dir_r[channel] != hbpwm_pkg::DIR_NONE &&
                   want != dir_r[channel]) begin
        rem_nxt[channel] = cfg.coast_calls;
        forced           = 1'b1;
      end else if (want != hbpwm_pkg::DIR_NONE) begin
        dir_nxt[channel] = want;
      end
    end
  end

  always_comb begin
    eff         = forced ? '0 : oriented;
    eff_abs     = eff[hbpwm_pkg::PCT_W-1] ? -eff : eff;
    cmd.channel = channel;
    cmd.neg     = eff[hbpwm_pkg::PCT_W-1];
    cmd.forced  = forced;
    cmd.mag     = eff_abs[hbpwm_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hbpwm_pkg::CHANNELS; i++) begin
        dir_r[i] <= hbpwm_pkg::DIR_NONE;
        rem_r[i] <= '0;
      end
    end else if (upd_en) begin
      dir_r <= dir_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

[design/hbpwm_checker.sv]
`default_nettype none

module hbpwm_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [hbpwm_pkg::CH_W-1:0]          out_channel,
  input wire logic [hbpwm_pkg::PERIOD_W-1:0]      out_in1_compare,
  input wire logic [hbpwm_pkg::PERIOD_W-1:0]      out_in2_compare,
  input wire logic                                out_coasting
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_in1_compare) &&
    $stable(out_in2_compare) && $stable(out_channel))
    else $error("stalled output transaction changed");

  // never drive both bridge inputs
  a_no_shoot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_in1_compare == '0) || (out_in2_compare == '0))
    else $error("both compare counts nonzero");

  // coasting forces both inputs low
  a_coast_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_coasting |-> (out_in1_compare == '0) && (out_in2_compare == '0))
    else $error("coasting with nonzero compare");

  // stalled coasting flag holds
  a_coast_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_coasting))
    else $error("stalled coasting flag changed");

endmodule

bind hbridge_pwm_with_reversal_coast hbpwm_checker u_hbpwm_checker (.*);

`default_nettype wire

[tb/sv/hbridge_pwm_with_reversal_coast_test.sv]
`timescale 1ns / 100ps

module hbridge_pwm_with_reversal_coast_test;
  import hbpwm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [PERIOD_W-1:0] in1;
    logic [PERIOD_W-1:0] in2;
    logic                coasting;
  } drive_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [CH_W-1:0]            in_channel;
  logic signed [DUTY_W-1:0]   in_duty_cmd;
  logic                       out_valid;
  logic                       out_ready;
  logic [CH_W-1:0]            out_channel;
  logic [PERIOD_W-1:0]        out_in1_compare;
  logic [PERIOD_W-1:0]        out_in2_compare;
  logic                       out_coasting;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  // bridge state as the block should hold it
  cfg_t                bridge_cfg;
  dir_t                last_dir [CHANNELS];
  logic [COAST_W-1:0]  coast_left [CHANNELS];

  drive_t              drive_q [$];
  int unsigned         err_cnt = 0;
  int unsigned         stall_cycles = 0;
  int unsigned         rx_hold = 0;
  bit                  idle_on = 1'b1;

  hbridge_pwm_with_reversal_coast uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_channel      (in_channel),
    .in_duty_cmd     (in_duty_cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_in1_compare (out_in1_compare),
    .out_in2_compare (out_in2_compare),
    .out_coasting    (out_coasting),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic drive_t predict_drive(input logic [CH_W-1:0] ch,
                                           input logic signed [DUTY_W-1:0] raw);
    drive_t      r;
    int          duty;
    int unsigned mag;
    dir_t        want;
    bit          inv;
    duty = raw;
    if (duty > 100) duty = 100;
    if (duty < -100) duty = -100;
    inv = (ch == 0) ? bridge_cfg.invert_left : bridge_cfg.invert_right;
    if (inv) duty = -duty;
    r.coasting = 1'b0;
    if (bridge_cfg.coast_calls != 0) begin
      want = (duty > 0) ? DIR_FWD : ((duty < 0) ? DIR_REV : DIR_NONE);
      if (coast_left[ch] != 0) begin
        coast_left[ch] = coast_left[ch] - 1'b1;
        duty = 0;
        r.coasting = 1'b1;
      end else if (want != DIR_NONE && last_dir[ch] != DIR_NONE && want != last_dir[ch]) begin
        coast_left[ch] = bridge_cfg.coast_calls;
        duty = 0;
        r.coasting = 1'b1;
      end else if (want != DIR_NONE) begin
        last_dir[ch] = want;
      end
    end
    mag = ((duty < 0) ? -duty : duty) * int'(bridge_cfg.pwm_period) / 100;
    if (mag > bridge_cfg.pwm_period) mag = bridge_cfg.pwm_period;
    r.channel = ch;
    r.in1 = (duty >= 0) ? mag[PERIOD_W-1:0] : '0;
    r.in2 = (duty < 0) ? mag[PERIOD_W-1:0] : '0;
    return r;
  endfunction

  function automatic logic signed [DUTY_W-1:0] rand_duty();
    int unsigned sel;
    int          v;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      v = $urandom_range(0, 65535);
    end else if (sel < 22) begin
      case ($urandom_range(0, 6))
        0: v = 0;
        1: v = 1;
        2: v = -1;
        3: v = 100;
        4: v = -100;
        5: v = 101;
        default: v = -101;
      endcase
    end else begin
      v = $urandom_range(0, 240);
      v = v - 120;
    end
    return DUTY_W'(v);
  endfunction

  // one command transaction, prediction made at acceptance
  task automatic send_cmd(input logic [CH_W-1:0] ch, input logic signed [DUTY_W-1:0] duty);
    while (idle_on && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_channel  <= ch;
    in_duty_cmd <= duty;
    do @(posedge clk); while (!in_ready);
    drive_q.push_back(predict_drive(ch, duty));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (drive_q.size() != 0);
  endtask

  task automatic set_config(input bit il, input bit ir, input logic [COAST_W-1:0] cc,
                            input logic [PERIOD_W-1:0] per);
    logic [CFG_DATA_W-1:0] val [4];
    cfg_reg_t              idx;
    val[0] = {15'($urandom), il};
    val[1] = {15'($urandom), ir};
    val[2] = {8'($urandom), cc};
    val[3] = per;
    for (int k = 0; k < 4; k++) begin
      idx = cfg_reg_t'(k);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        REG_INVERT_LEFT:  bridge_cfg.invert_left  = val[k][0];
        REG_INVERT_RIGHT: bridge_cfg.invert_right = val[k][0];
        REG_COAST_CALLS:  bridge_cfg.coast_calls  = val[k][COAST_W-1:0];
        REG_PWM_PERIOD:   bridge_cfg.pwm_period   = val[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // reset configuration: saturation, zero duty, reversal and coast countdown
  task automatic test_default_mapping();
    send_cmd(1'b0, 16'sh7fff);
    send_cmd(1'b0, 16'sd0);
    send_cmd(1'b1, 16'sd100);
    send_cmd(1'b0, 16'sh8000);
    send_cmd(1'b0, 16'sd101);
    send_cmd(1'b0, -16'sd1);
    send_cmd(1'b1, 16'sh8001);
    send_cmd(1'b0, 16'sd0);
    send_cmd(1'b0, -16'sd101);
    send_cmd(1'b0, 16'sd1);
    send_cmd(1'b1, -16'sd1);
    send_cmd(1'b0, 16'sd99);
    send_cmd(1'b1, 16'sd55);
    send_cmd(1'b0, 16'sd50);
    wait_idle();
  endtask

  // zero period, disabled protection, widest period, longest coast
  task automatic test_config_extremes();
    set_config(1'b0, 1'b0, 8'd0, 16'd0);
    send_cmd(1'b0, 16'sd100);
    send_cmd(1'b0, -16'sd100);
    send_cmd(1'b1, -16'sd50);
    wait_idle();
    set_config(1'b1, 1'b0, 8'd0, 16'hffff);
    send_cmd(1'b0, 16'sd100);
    send_cmd(1'b0, -16'sd100);
    send_cmd(1'b1, -16'sd37);
    send_cmd(1'b1, 16'sd1);
    wait_idle();
    set_config(1'b1, 1'b1, 8'd255, 16'd1);
    send_cmd(1'b0, -16'sd100);
    send_cmd(1'b1, 16'sd100);
    send_cmd(1'b1, -16'sd100);
    send_cmd(1'b0, 16'sd50);
    wait_idle();
  endtask

  // receiver holds off while commands keep coming, so the input backs up
  task automatic test_output_stall();
    set_config(1'b0, 1'b1, 8'd3, 16'd1000);
    idle_on = 1'b0;
    rx_hold = 200;
    for (int i = 0; i < 30; i++) send_cmd(1'($urandom), rand_duty());
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int unsigned phases, input int unsigned per_phase);
    logic [COAST_W-1:0]  cc;
    logic [PERIOD_W-1:0] per;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 5))
        0: cc = 8'd0;
        1: cc = 8'd1;
        2: cc = 8'($urandom_range(0, 255));
        default: cc = 8'($urandom_range(2, 6));
      endcase
      case ($urandom_range(0, 4))
        0: per = 16'd1;
        1: per = 16'hffff;
        2: per = 16'd100;
        default: per = 16'($urandom_range(1, 65535));
      endcase
      set_config(1'($urandom), 1'($urandom), cc, per);
      idle_on = (p != 2);
      for (int i = 0; i < per_phase; i++) send_cmd(1'($urandom), rand_duty());
      wait_idle();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    int unsigned n;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold != 0) begin
        n = rx_hold;
        rx_hold = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= !(idle_on && $urandom_range(0, 99) < 17);
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    drive_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (drive_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected result: ch %0d in1 %0d in2 %0d coast %0b",
                   out_channel, out_in1_compare, out_in2_compare, out_coasting);
      end else begin
        exp_r = drive_q.pop_front();
        if (out_channel !== exp_r.channel || out_in1_compare !== exp_r.in1 ||
            out_in2_compare !== exp_r.in2 || out_coasting !== exp_r.coasting) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("mismatch: expected ch %0d in1 %0d in2 %0d coast %0b, got ch %0d in1 %0d in2 %0d coast %0b",
                     exp_r.channel, exp_r.in1, exp_r.in2, exp_r.coasting,
                     out_channel, out_in1_compare, out_in2_compare, out_coasting);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("hbridge_pwm_with_reversal_coast_test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_channel  = '0;
    in_duty_cmd = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    bridge_cfg  = '{invert_left: 1'b0, invert_right: 1'b1,
                    coast_calls: COAST_RESET, pwm_period: PERIOD_RESET};
    for (int c = 0; c < CHANNELS; c++) begin
      last_dir[c]   = DIR_NONE;
      coast_left[c] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_default_mapping();
    test_config_extremes();
    test_output_stall();
    test_random_traffic(6, 90);

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && drive_q.size() == 0) begin
      $display("hbridge_pwm_with_reversal_coast_test passed");
    end else begin
      $display("hbridge_pwm_with_reversal_coast_test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/hbpwm_pkg.sv
design/hbpwm_dir.sv
design/hbridge_pwm_with_reversal_coast.sv
design/hbpwm_checker.sv
tb/sv/hbridge_pwm_with_reversal_coast_test.sv
